/* hdl/sucst_pkg.sv */
// Shared types and constants for the sound unit control/status timing block.
// No dependencies; imported by sound_unit_control_status_timing.
package sucst_pkg;

	// Item kinds carried in the input tuser field
	typedef enum logic [1:0] {
		MODE_CTRL_WRITE = 2'd0,
		MODE_TICK       = 2'd1,
		MODE_DMA_NOTE   = 2'd2,
		MODE_IRQ_RAISE  = 2'd3
	} mode_t;

	// Field widths
	localparam int unsigned WordW   = 16;
	localparam int unsigned ModeW   = 6;
	localparam int unsigned ApplyW  = 10;
	localparam int unsigned BusyW   = 12;
	localparam int unsigned InDataW = 56;
	localparam int unsigned OutDataW = 40;

	// Mode register decode
	localparam logic [ModeW-1:0] XferMask     = 6'h30;
	localparam logic [ModeW-1:0] XferDmaWrite = 6'h20;
	localparam logic [ModeW-1:0] XferDmaRead  = 6'h30;

	// Control word enable bits
	localparam int unsigned CtlIrqEnBit  = 6;
	localparam int unsigned CtlUnitEnBit = 15;

	// Status word bits
	localparam int unsigned StIrqBit   = 6;
	localparam int unsigned StDmaReq   = 7;
	localparam int unsigned StDmaWrReq = 8;
	localparam int unsigned StDmaRdReq = 9;
	localparam int unsigned StBusyBit  = 10;

	// Timing
	localparam logic [ApplyW-1:0] DelayCycles = 10'h300;
	localparam logic [WordW-1:0]  WordCap     = 16'h0100;
	localparam logic [BusyW-1:0]  BusyMax     = 12'd2816;

endpackage

/* hdl/sound_unit_control_status_timing.sv */
// Control/status timing of a sound unit: state update and status compose.
// Depends on sucst_pkg (types, field widths, timing constants).
//
// Usage:
//   Input stream (s_axis_*): one item per transfer. tuser carries the item
//   kind (control write, time tick, DMA note, interrupt raise); tdata carries
//   the operands. Output stream (m_axis_*): exactly one result per input
//   item, in order: the status word, the interrupt request and the control
//   readback, all taken after that item's update.
//   Flow: an accepted item waits in the input register until the output
//   register is free or drains, then its result is loaded into the output
//   register and offered there. Throughput: one item per cycle while the
//   receiver does not stall; the update is a few compares and subtracts
//   between the input register and the output register, and the state
//   registers close the loop on the same edge that loads the output register.
//   When the receiver stalls, the output register holds its result and the
//   input register holds one more item; s_axis_tready drops only when both
//   are full.
//   Reset (arst_n low, asynchronous): all state clears to zero, both
//   registers empty, no result pending.
module sound_unit_control_status_timing
	import sucst_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// [15:0] write_value, [31:16] tick_cycles, [32] dma_from_ram,
	// [48:33] dma_words, [55:49] zero
	input  logic [InDataW-1:0]  s_axis_tdata,
	// [1:0] mode
	input  logic [1:0]          s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// [15:0] status_word, [16] irq_request, [32:17] control_readback,
	// [39:33] zero
	output logic [OutDataW-1:0] m_axis_tdata
);

	// Input register
	logic             valid_s1;
	mode_t            mode_s1;
	logic [WordW-1:0] write_value_s1;
	logic [WordW-1:0] tick_cycles_s1;
	logic             dma_from_ram_s1;
	logic [WordW-1:0] dma_words_s1;

	// Unit state
	logic [WordW-1:0]  control_word_q;
	logic [ModeW-1:0]  pending_mode_q;
	logic [ModeW-1:0]  applied_mode_q;
	logic [ApplyW-1:0] apply_countdown_q;
	logic [ApplyW-1:0] warmup_countdown_q;
	logic [BusyW-1:0]  busy_countdown_q;
	logic              irq_flag_q;

	// Next state
	logic [WordW-1:0]  control_word_d;
	logic [ModeW-1:0]  pending_mode_d;
	logic [ModeW-1:0]  applied_mode_d;
	logic [ApplyW-1:0] apply_countdown_d;
	logic [ApplyW-1:0] warmup_countdown_d;
	logic [BusyW-1:0]  busy_countdown_d;
	logic              irq_flag_d;

	logic             advance;
	logic             both_en_d;
	logic             apply_done;
	logic [8:0]       words_capped;
	logic [BusyW-1:0] dma_len;
	logic             dma_match;
	logic             wr_req;
	logic             rd_req;
	logic [WordW-1:0] status_d;
	logic             irq_req_d;

	// Handshake: stage 1 moves on when the output register is free or drains
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1         <= mode_t'(s_axis_tuser);
			write_value_s1  <= s_axis_tdata[15:0];
			tick_cycles_s1  <= s_axis_tdata[31:16];
			dma_from_ram_s1 <= s_axis_tdata[32];
			dma_words_s1    <= s_axis_tdata[48:33];
		end
	end

	// DMA busy length: 768 + 8 per word, words capped
	assign words_capped = (dma_words_s1 < WordCap) ? dma_words_s1[8:0] : WordCap[8:0];
	assign dma_len      = BusyW'(DelayCycles) + {words_capped, 3'b000};
	assign dma_match    = (dma_from_ram_s1 && ((applied_mode_q & XferMask) == XferDmaWrite)) ||
		(!dma_from_ram_s1 && ((applied_mode_q & XferMask) == XferDmaRead));
	assign apply_done   = (apply_countdown_q != '0) &&
		(tick_cycles_s1 >= WordW'(apply_countdown_q));

	// State update for the item in stage 1
	always_comb begin
		control_word_d     = control_word_q;
		pending_mode_d     = pending_mode_q;
		applied_mode_d     = applied_mode_q;
		apply_countdown_d  = apply_countdown_q;
		warmup_countdown_d = warmup_countdown_q;
		busy_countdown_d   = busy_countdown_q;
		irq_flag_d         = irq_flag_q;
		case (mode_s1)
			MODE_CTRL_WRITE: begin
				control_word_d    = write_value_s1;
				if (!(write_value_s1[CtlIrqEnBit] && write_value_s1[CtlUnitEnBit]))
					irq_flag_d = 1'b0;
				pending_mode_d    = write_value_s1[ModeW-1:0];
				apply_countdown_d = DelayCycles;
			end
			MODE_TICK: begin
				// apply, warmup and busy countdowns; on apply completion load the new mode and reload warmup
				if (apply_done) begin
					apply_countdown_d  = '0;
					applied_mode_d     = pending_mode_q;
					warmup_countdown_d = ((pending_mode_q & XferMask) == XferDmaRead) ?
						DelayCycles : '0;
				end else begin
					if (apply_countdown_q != '0)
						apply_countdown_d = apply_countdown_q - tick_cycles_s1[ApplyW-1:0];
					if (warmup_countdown_q != '0) begin
						if (tick_cycles_s1 >= WordW'(warmup_countdown_q))
							warmup_countdown_d = '0;
						else
							warmup_countdown_d = warmup_countdown_q -
								tick_cycles_s1[ApplyW-1:0];
					end
				end
				if (busy_countdown_q != '0) begin
					if (tick_cycles_s1 >= WordW'(busy_countdown_q))
						busy_countdown_d = '0;
					else
						busy_countdown_d = busy_countdown_q - tick_cycles_s1[BusyW-1:0];
				end
			end
			MODE_DMA_NOTE: begin
				if (dma_match && (dma_words_s1 != '0) && (dma_len > busy_countdown_q))
					busy_countdown_d = dma_len;
			end
			MODE_IRQ_RAISE: begin
				irq_flag_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Status composition from the updated state
	assign both_en_d = control_word_d[CtlIrqEnBit] && control_word_d[CtlUnitEnBit];
	assign wr_req    = (applied_mode_d & XferMask) == XferDmaWrite;
	assign rd_req    = ((applied_mode_d & XferMask) == XferDmaRead) &&
		(warmup_countdown_d == '0) && (apply_countdown_d == '0);
	assign irq_req_d = irq_flag_d && both_en_d;

	always_comb begin
		status_d              = '0;
		status_d[ModeW-1:0]   = applied_mode_d;
		status_d[StIrqBit]    = irq_flag_d;
		status_d[StDmaReq]    = wr_req || rd_req;
		status_d[StDmaWrReq]  = wr_req;
		status_d[StDmaRdReq]  = rd_req;
		status_d[StBusyBit]   = (apply_countdown_d != '0) || (warmup_countdown_d != '0) ||
			(busy_countdown_d != '0);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_word_q     <= '0;
			pending_mode_q     <= '0;
			applied_mode_q     <= '0;
			apply_countdown_q  <= '0;
			warmup_countdown_q <= '0;
			busy_countdown_q   <= '0;
			irq_flag_q         <= 1'b0;
		end else if (advance) begin
			control_word_q     <= control_word_d;
			pending_mode_q     <= pending_mode_d;
			applied_mode_q     <= applied_mode_d;
			apply_countdown_q  <= apply_countdown_d;
			warmup_countdown_q <= warmup_countdown_d;
			busy_countdown_q   <= busy_countdown_d;
			irq_flag_q         <= irq_flag_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			m_axis_tdata <= {7'b0, control_word_d, irq_req_d, status_d};
	end

	// Checks
	a_apply_bound: assert property (@(posedge clk) disable iff (!arst_n)
		apply_countdown_q <= DelayCycles)
		else $error("apply countdown above delay");

	a_busy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_countdown_q <= BusyMax)
		else $error("busy countdown above longest DMA length");

	a_irq_raise: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (mode_s1 == MODE_IRQ_RAISE) |=> irq_flag_q && m_axis_tdata[StIrqBit])
		else $error("interrupt raise not reflected");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

endmodule

/* test/tb.sv */
// Self-checking testbench for sound_unit_control_status_timing: stream driver,
// result monitor and an item-level status predictor. Depends on sucst_pkg.
// Directed corner items first, then random traffic under three stall patterns.
module tb;
	import sucst_pkg::*;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned DrainCycles = 8;
	localparam int unsigned WordCycles = 8;
	localparam int unsigned PhaseItems = 620;

	typedef struct {
		mode_t       kind;
		logic [15:0] wval;
		logic [15:0] cycles;
		logic        from_ram;
		logic [15:0] words;
	} sound_item_t;

	typedef struct {
		logic [15:0] status;
		logic        irq_req;
		logic [15:0] ctl;
	} sound_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic [1:0]          s_tuser = MODE_CTRL_WRITE;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;

	sound_unit_control_status_timing dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata (s_tdata),
		.s_axis_tuser (s_tuser),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_tdata)
	);

	// Stimulus and expectation stores
	sound_item_t   pending_items[$];
	sound_result_t expected_status[$];
	int unsigned   queued_count = 0;
	int unsigned   accepted_count = 0;
	int unsigned   checked_count = 0;
	int unsigned   directed_count = 0;
	int unsigned   error_count = 0;
	int unsigned   cycle_count = 0;
	int unsigned   send_idle_pct = 10;
	int unsigned   recv_idle_pct = 56;
	logic          in_fire = 1'b0;

	// Predictor state
	logic [15:0] ctl_word = '0;
	logic [5:0]  pend_mode = '0;
	logic [5:0]  appl_mode = '0;
	logic [9:0]  apply_left = '0;
	logic [9:0]  warm_left = '0;
	logic [11:0] busy_left = '0;
	logic        irq_flag = 1'b0;

	function automatic logic both_enabled();
		return ctl_word[CtlIrqEnBit] && ctl_word[CtlUnitEnBit];
	endfunction

	// Apply one item to the predicted state and compose the status it returns
	function automatic sound_result_t step_sound_state(input sound_item_t it);
		sound_result_t res;
		logic [5:0]    xfer;
		logic          applied;
		logic          wr_req;
		logic          rd_req;
		int unsigned   n;
		int unsigned   len;
		case (it.kind)
			MODE_CTRL_WRITE: begin
				ctl_word = it.wval;
				if (!both_enabled())
					irq_flag = 1'b0;
				pend_mode = it.wval[5:0];
				apply_left = DelayCycles;
			end
			MODE_TICK: begin
				applied = (apply_left != 0) && (it.cycles >= 16'(apply_left));
				apply_left = (it.cycles >= 16'(apply_left)) ? '0 :
					apply_left - it.cycles[9:0];
				// completing apply reloads warmup instead of counting it down
				if (applied) begin
					appl_mode = pend_mode;
					warm_left = ((appl_mode & XferMask) == XferDmaRead) ? DelayCycles : '0;
				end else begin
					warm_left = (it.cycles >= 16'(warm_left)) ? '0 :
						warm_left - it.cycles[9:0];
				end
				busy_left = (it.cycles >= 16'(busy_left)) ? '0 :
					busy_left - it.cycles[11:0];
			end
			MODE_DMA_NOTE: begin
				xfer = appl_mode & XferMask;
				if (((it.from_ram && xfer == XferDmaWrite) ||
						(!it.from_ram && xfer == XferDmaRead)) && it.words != 0) begin
					n = 32'((it.words < WordCap) ? it.words : WordCap);
					len = 32'(DelayCycles) + n * WordCycles;
					// busy is only ever extended
					if (len > 32'(busy_left))
						busy_left = 12'(len);
				end
			end
			default: begin
				irq_flag = 1'b1;
			end
		endcase
		xfer = appl_mode & XferMask;
		wr_req = (xfer == XferDmaWrite);
		rd_req = (xfer == XferDmaRead) && warm_left == 0 && apply_left == 0;
		res.status = {10'b0, appl_mode};
		res.status[StIrqBit] = irq_flag;
		res.status[StDmaReq] = wr_req || rd_req;
		res.status[StDmaWrReq] = wr_req;
		res.status[StDmaRdReq] = rd_req;
		res.status[StBusyBit] = (apply_left != 0) || (warm_left != 0) || (busy_left != 0);
		res.irq_req = irq_flag && both_enabled();
		res.ctl = ctl_word;
		return res;
	endfunction

	function automatic sound_item_t mk_item(input mode_t kind, input logic [15:0] wval,
			input logic [15:0] cycles, input logic from_ram, input logic [15:0] words);
		sound_item_t it;
		it.kind = kind;
		it.wval = wval;
		it.cycles = cycles;
		it.from_ram = from_ram;
		it.words = words;
		return it;
	endfunction

	// Random item biased toward sequences that reach apply, warmup and busy
	function automatic sound_item_t rand_item();
		sound_item_t it;
		int unsigned pick;
		int unsigned sub;
		pick = $urandom_range(99);
		sub = $urandom_range(99);
		it = mk_item(MODE_TICK, 16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
		if (pick < 20) begin
			it.kind = MODE_CTRL_WRITE;
			if (sub < 30)
				it.wval[5:0] = (it.wval[5:0] & ~XferMask) | XferDmaWrite;
			else if (sub < 60)
				it.wval[5:0] = (it.wval[5:0] & ~XferMask) | XferDmaRead;
			if ($urandom_range(99) < 40) begin
				it.wval[CtlIrqEnBit] = 1'b1;
				it.wval[CtlUnitEnBit] = 1'b1;
			end
		end else if (pick < 60) begin
			it.kind = MODE_TICK;
			if (sub < 10)
				it.cycles = '0;
			else if (sub < 60)
				it.cycles = 16'($urandom_range(1, 64));
			else if (sub < 85)
				it.cycles = 16'($urandom_range(1, 1023));
		end else if (pick < 88) begin
			it.kind = MODE_DMA_NOTE;
			if (sub < 10)
				it.words = '0;
			else if (sub < 70)
				it.words = 16'($urandom_range(1, 300));
		end else begin
			it.kind = MODE_IRQ_RAISE;
		end
		return it;
	endfunction

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Input driver: new transfer offered only once the previous one is taken
	always @(negedge clk) begin
		sound_item_t it;
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				it = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= it.kind;
				s_tdata <= {7'b0, it.words, it.from_ram, it.cycles, it.wval};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: predict on input transfer, check on output transfer
	always @(posedge clk) begin
		sound_item_t   it;
		sound_result_t want;
		in_fire <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			it = mk_item(mode_t'(s_tuser), s_tdata[15:0], s_tdata[31:16], s_tdata[32],
				s_tdata[48:33]);
			expected_status.insert(expected_status.size(), step_sound_state(it));
			accepted_count++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_status.size() == 0) begin
				$error("unexpected result transfer: tdata %h", m_tdata);
				error_count++;
			end else begin
				want = expected_status.pop_front();
				checked_count++;
				if (m_tdata[15:0] !== want.status) begin
					$error("status_word: expected %h, got %h", want.status, m_tdata[15:0]);
					error_count++;
				end
				if (m_tdata[16] !== want.irq_req) begin
					$error("irq_request: expected %b, got %b", want.irq_req, m_tdata[16]);
					error_count++;
				end
				if (m_tdata[32:17] !== want.ctl) begin
					$error("control_readback: expected %h, got %h", want.ctl, m_tdata[32:17]);
					error_count++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", cycle_count);
		$display("Mismatches found");
		$finish;
	end

	task automatic queue_item(input sound_item_t it);
		pending_items.insert(pending_items.size(), it);
		queued_count++;
	endtask

	// Hold off until every queued item is taken and every result has come back
	task automatic wait_drained();
		while (!(pending_items.size() == 0 && accepted_count == queued_count &&
				expected_status.size() == 0))
			@(posedge clk);
	endtask

	// Sequencer
	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: irq raise/keep/clear, apply timing, warmup, DMA busy extension
		queue_item(mk_item(MODE_IRQ_RAISE, 16'h0000, 16'h0000, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_CTRL_WRITE, 16'h0000, 16'h0000, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_IRQ_RAISE, 16'h0000, 16'h0000, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_CTRL_WRITE, 16'h8040, 16'h0000, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_CTRL_WRITE, 16'hFFFF, 16'h0000, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_TICK, 16'h0000, 16'h0000, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_TICK, 16'h0000, 16'd767, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_TICK, 16'h0000, 16'd1, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_DMA_NOTE, 16'h0000, 16'h0000, 1'b0, 16'd5));
		queue_item(mk_item(MODE_TICK, 16'h0000, 16'd100, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_DMA_NOTE, 16'h0000, 16'h0000, 1'b1, 16'd5));
		queue_item(mk_item(MODE_TICK, 16'h0000, 16'hFFFF, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_DMA_NOTE, 16'h0000, 16'h0000, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_DMA_NOTE, 16'h0000, 16'h0000, 1'b0, 16'hFFFF));
		queue_item(mk_item(MODE_DMA_NOTE, 16'h0000, 16'h0000, 1'b0, 16'd1));
		queue_item(mk_item(MODE_CTRL_WRITE, 16'h0060, 16'h0000, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_TICK, 16'h0000, 16'd768, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_DMA_NOTE, 16'h0000, 16'h0000, 1'b1, 16'd256));
		queue_item(mk_item(MODE_DMA_NOTE, 16'h0000, 16'h0000, 1'b0, 16'd256));
		queue_item(mk_item(MODE_TICK, 16'h0000, 16'd1000, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_TICK, 16'h0000, 16'hFFFF, 1'b0, 16'h0000));
		queue_item(mk_item(MODE_IRQ_RAISE, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF));
		queue_item(mk_item(MODE_CTRL_WRITE, 16'h7FBF, 16'hFFFF, 1'b1, 16'hFFFF));
		directed_count = queued_count;

		// Phase 1: sender rarely idle, receiver often stalls
		for (int i = 0; i < PhaseItems; i++)
			queue_item(rand_item());
		wait_drained();

		// Phase 2: roles swapped
		send_idle_pct = 56;
		recv_idle_pct = 10;
		for (int i = 0; i < PhaseItems; i++)
			queue_item(rand_item());
		wait_drained();

		// Phase 3: full rate both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < PhaseItems; i++)
			queue_item(rand_item());
		wait_drained();

		repeat (DrainCycles) @(posedge clk);
		if (expected_status.size() != 0) begin
			$error("%0d expected results never arrived", expected_status.size());
			error_count += expected_status.size();
		end

		$display("Run covered %0d items (%0d directed) across three stall patterns,",
			accepted_count, directed_count);
		$display("%0d results compared in %0d cycles.", checked_count, cycle_count);
		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
